// File: hdl/asir_pkg.sv
package asir_pkg;

   // Array geometry. The port fields fix the fill count at nine bits.
   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = 9;
   localparam int WORD_W = 32;
   localparam int AMT_W  = 16;

   // Request modes.
   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_REMOVE = 3'd1;
   localparam logic [2:0] MODE_ROT_R  = 3'd2;
   localparam logic [2:0] MODE_ROT_L  = 3'd3;
   localparam logic [2:0] MODE_READ   = 3'd4;
   localparam logic [2:0] MODE_CLEAR  = 3'd5;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]               mode;
      logic [CNT_W-1:0]         position;
      logic signed [WORD_W-1:0] item_value;
      logic [AMT_W-1:0]         amount;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] read_value;
      logic [CNT_W-1:0]         fill_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MODRED,
      ST_COPY,
      ST_DRAIN,
      ST_RDWAIT,
      ST_FINISH
   } state_type;

endpackage

// File: hdl/asir_ram.sv
module asir_ram #(
   parameter int WIDTH = asir_pkg::WORD_W,
   parameter int DEPTH = asir_pkg::DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/asir_mod.sv
module asir_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [asir_pkg::AMT_W-1:0] dividend,
   input  logic [asir_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [asir_pkg::CNT_W-1:0] remainder
);

   localparam int STEP_W = $clog2(asir_pkg::AMT_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [asir_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [asir_pkg::AMT_W-1:0] sh_ff, sh_in;
   logic [asir_pkg::CNT_W:0]   trial;
   logic [asir_pkg::CNT_W:0]   diff;

   // Restoring remainder, one dividend bit per cycle, most significant first.
   assign trial = {rem_ff, sh_ff[asir_pkg::AMT_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         sh_in   = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[asir_pkg::CNT_W-1:0];
         end else begin
            rem_in = trial[asir_pkg::CNT_W-1:0];
         end
         sh_in   = {sh_ff[asir_pkg::AMT_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(asir_pkg::AMT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/array_shift_insert_remove_rotate.sv
// Packed-array edit engine: up to 256 signed words at positions below the
// fill count. Each request word on the req_ channel names a mode (insert,
// remove, rotate right or left, read, clear) and gets exactly one response
// word on the rsp_ channel with a status, the word read and the new count.
// The words live in two banks of RAM. A change to the array streams the
// valid entries from the active bank into the other one with the index
// remapped (one entry per cycle through the registered read port), then
// swaps banks. The number of entries copied, len, is count + 1 for insert,
// count - 1 for remove and count for rotate. Rotation first reduces the
// amount modulo count in a bit-serial remainder unit. One request is
// handled at a time; req_stall is high while it is at work. The response
// waits in an output register while rsp_stall is high, and the next
// request may be accepted meanwhile. Reset empties the array at once (the
// count goes to zero); no clearing pass is needed.
module array_shift_insert_remove_rotate (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  asir_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output asir_pkg::rsp_type rsp_data
);

   localparam int AW = asir_pkg::ADDR_W;
   localparam int CW = asir_pkg::CNT_W;
   localparam int WW = asir_pkg::WORD_W;

   asir_pkg::state_type state_ff, state_in;
   asir_pkg::req_type   req_ff, req_in;
   asir_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       new_count_ff, new_count_in;
   logic [CW-1:0]       dst_ff, dst_in;
   logic [CW-1:0]       src_ff, src_in;
   logic [CW-1:0]       len_ff, len_in;
   logic                bank_ff, bank_in;
   logic [1:0]          status_ff, status_in;
   logic [WW-1:0]       read_ff, read_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   logic                wr_val_ff, wr_val_in;

   logic                ins_bad, ins_full, idx_bad, rot_mode, out_free;
   logic [CW-1:0]       src_sel;
   logic [AW-1:0]       rd_addr;
   logic [WW-1:0]       rd_data0, rd_data1, rd_active, wr_data;
   logic                mod_start, mod_done;
   logic [CW-1:0]       mod_rem;

   // Request checks against the current count.
   assign ins_bad  = req_ff.position > count_ff;
   assign ins_full = count_ff >= CW'(asir_pkg::DEPTH);
   assign idx_bad  = req_ff.position >= count_ff;
   assign rot_mode = (req_ff.mode == asir_pkg::MODE_ROT_R) ||
                     (req_ff.mode == asir_pkg::MODE_ROT_L);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         asir_pkg::ST_IDLE: begin
            if (req_valid) state_in = asir_pkg::ST_DECIDE;
         end
         asir_pkg::ST_DECIDE: begin
            state_in = asir_pkg::ST_FINISH;
            case (req_ff.mode)
               asir_pkg::MODE_INSERT: begin
                  if (!ins_bad && !ins_full) state_in = asir_pkg::ST_COPY;
               end
               asir_pkg::MODE_REMOVE: begin
                  if (!idx_bad && count_ff != CW'(1)) state_in = asir_pkg::ST_COPY;
               end
               asir_pkg::MODE_ROT_R, asir_pkg::MODE_ROT_L: begin
                  if (count_ff != '0) state_in = asir_pkg::ST_MODRED;
               end
               asir_pkg::MODE_READ: begin
                  if (!idx_bad) state_in = asir_pkg::ST_RDWAIT;
               end
               default: state_in = asir_pkg::ST_FINISH;
            endcase
         end
         asir_pkg::ST_MODRED: begin
            if (mod_done) begin
               state_in = (mod_rem == '0) ? asir_pkg::ST_FINISH : asir_pkg::ST_COPY;
            end
         end
         asir_pkg::ST_COPY: begin
            if (dst_ff + CW'(1) == len_ff) state_in = asir_pkg::ST_DRAIN;
         end
         asir_pkg::ST_DRAIN:  state_in = asir_pkg::ST_FINISH;
         asir_pkg::ST_RDWAIT: state_in = asir_pkg::ST_FINISH;
         asir_pkg::ST_FINISH: begin
            if (out_free) state_in = asir_pkg::ST_IDLE;
         end
         default: state_in = asir_pkg::ST_IDLE;
      endcase
   end

   // Source index of the entry that lands at the current destination.
   always_comb begin
      case (req_ff.mode)
         asir_pkg::MODE_INSERT: src_sel = (dst_ff > req_ff.position) ? dst_ff - CW'(1) : dst_ff;
         asir_pkg::MODE_REMOVE: src_sel = (dst_ff >= req_ff.position) ? dst_ff + CW'(1) : dst_ff;
         default:               src_sel = src_ff;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      count_in     = count_ff;
      new_count_in = new_count_ff;
      dst_in       = dst_ff;
      src_in       = src_ff;
      len_in       = len_ff;
      bank_in      = bank_ff;
      status_in    = status_ff;
      read_in      = read_ff;
      mod_start    = 1'b0;
      rd_addr      = req_ff.position[AW-1:0];
      case (state_ff)
         asir_pkg::ST_IDLE: begin
            req_in = req_data;
         end
         asir_pkg::ST_DECIDE: begin
            status_in = asir_pkg::STATUS_OK;
            read_in   = '0;
            dst_in    = '0;
            case (req_ff.mode)
               asir_pkg::MODE_INSERT: begin
                  if (ins_bad) begin
                     status_in = asir_pkg::STATUS_RANGE;
                  end else if (ins_full) begin
                     status_in = asir_pkg::STATUS_FULL;
                  end else begin
                     len_in       = count_ff + CW'(1);
                     new_count_in = count_ff + CW'(1);
                  end
               end
               asir_pkg::MODE_REMOVE: begin
                  if (idx_bad) begin
                     status_in = asir_pkg::STATUS_RANGE;
                  end else begin
                     len_in       = count_ff - CW'(1);
                     new_count_in = count_ff - CW'(1);
                     if (count_ff == CW'(1)) count_in = '0;
                  end
               end
               asir_pkg::MODE_ROT_R, asir_pkg::MODE_ROT_L: begin
                  mod_start = (count_ff != '0);
               end
               asir_pkg::MODE_READ: begin
                  if (idx_bad) status_in = asir_pkg::STATUS_RANGE;
               end
               asir_pkg::MODE_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  status_in = asir_pkg::STATUS_OK;
               end
            endcase
         end
         asir_pkg::ST_MODRED: begin
            // Right by r starts at count - r; left by r starts at r.
            if (mod_done && mod_rem != '0) begin
               len_in       = count_ff;
               new_count_in = count_ff;
               dst_in       = '0;
               src_in       = (req_ff.mode == asir_pkg::MODE_ROT_R) ?
                              count_ff - mod_rem : mod_rem;
            end
         end
         asir_pkg::ST_COPY: begin
            rd_addr = src_sel[AW-1:0];
            dst_in  = dst_ff + CW'(1);
            src_in  = (src_ff + CW'(1) == count_ff) ? '0 : src_ff + CW'(1);
         end
         asir_pkg::ST_DRAIN: begin
            bank_in  = !bank_ff;
            count_in = new_count_ff;
         end
         asir_pkg::ST_RDWAIT: begin
            read_in = rd_active;
         end
         asir_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_in.status     = status_ff;
               rsp_in.read_value = read_ff;
               rsp_in.fill_count = count_ff;
               rsp_valid_in      = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // Write stage, in the cycle after the read of the same entry.
   assign wr_pend_in = (state_ff == asir_pkg::ST_COPY);
   assign wr_addr_in = dst_ff[AW-1:0];
   assign wr_val_in  = (req_ff.mode == asir_pkg::MODE_INSERT) &&
                       (dst_ff == req_ff.position);
   assign rd_active  = bank_ff ? rd_data1 : rd_data0;
   assign wr_data    = wr_val_ff ? req_ff.item_value : rd_active;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asir_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         wr_pend_ff   <= wr_pend_in;
      end
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      new_count_ff <= new_count_in;
      dst_ff       <= dst_in;
      src_ff       <= src_in;
      len_ff       <= len_in;
      status_ff    <= status_in;
      read_ff      <= read_in;
      wr_addr_ff   <= wr_addr_in;
      wr_val_ff    <= wr_val_in;
   end

   // Two banks: read the active one, write the other.
   asir_ram #(
      .WIDTH (asir_pkg::WORD_W),
      .DEPTH (asir_pkg::DEPTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_pend_ff && bank_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   asir_ram #(
      .WIDTH (asir_pkg::WORD_W),
      .DEPTH (asir_pkg::DEPTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_pend_ff && !bank_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   // Rotation amount modulo count.
   asir_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_ff.amount),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_stall = (state_ff != asir_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The fill count never passes the array depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(asir_pkg::DEPTH))
      else $error("fill count exceeds depth");

   // Bank writes only happen while a copy is streaming.
   assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == asir_pkg::ST_COPY || state_ff == asir_pkg::ST_DRAIN))
      else $error("bank write outside a copy");

   // The copy index stays below its length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == asir_pkg::ST_COPY) |-> (dst_ff < len_ff))
      else $error("copy index overran its length");

   // A fresh response reports the count that the request left.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_ff.fill_count == count_ff))
      else $error("response count differs from array count");

   // The remainder unit only runs for rotate requests.
   assert property (@(posedge clock) disable iff (reset)
      mod_start |-> rot_mode)
      else $error("remainder started outside rotate");

endmodule

// File: verif/tb_array_shift_insert_remove_rotate.sv
`timescale 1ns / 1ps

module tb_array_shift_insert_remove_rotate;
   import asir_pkg::*;

   // Mode codes that the block ignores.
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   localparam int RANDOM_WORDS = 1050;
   localparam int CYCLE_LIMIT  = 1_200_000;
   localparam int TAIL_CYCLES  = 300;
   localparam int QUIET_TAIL   = 50;

   typedef struct {
      req_type word;
      bit      drain;
   } pending_word_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   array_shift_insert_remove_rotate dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Shadow copy of the array and its fill count.
   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int shadow_count;

   pending_word_type send_q [$];
   rsp_type          expected_rsp_q [$];

   int  gen_fill;
   int  real_words;
   int  err_count;
   int  cycle_cnt;
   int  rsp_seen;
   int  send_gap;
   int  stall_left;
   int  peak_fill;
   int  mode_hits [8];
   int  status_hits [4];
   logic req_taken;

   // Clock generation.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      err_count++;
      $display("MISMATCH at response %0d (cycle %0d): %s", rsp_seen, cycle_cnt, msg);
   endtask

   // Applies one request to the shadow array and returns the response it earns.
   function automatic rsp_type apply_request(req_type w);
      rsp_type r;
      int i;
      int rot;
      logic signed [WORD_W-1:0] turned [DEPTH];
      r = '0;
      case (w.mode)
         MODE_INSERT: begin
            if (w.position > shadow_count) begin
               r.status = STATUS_RANGE;
            end else if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               for (i = shadow_count; i > w.position; i--) begin
                  shadow_words[i] = shadow_words[i-1];
               end
               shadow_words[w.position] = w.item_value;
               shadow_count++;
            end
         end
         MODE_REMOVE: begin
            if (w.position >= shadow_count) begin
               r.status = STATUS_RANGE;
            end else begin
               for (i = w.position; i + 1 < shadow_count; i++) begin
                  shadow_words[i] = shadow_words[i+1];
               end
               shadow_count--;
            end
         end
         MODE_ROT_R, MODE_ROT_L: begin
            if (shadow_count > 0) begin
               rot = int'(w.amount) % shadow_count;
               if (rot != 0) begin
                  if (w.mode == MODE_ROT_L) begin
                     rot = shadow_count - rot;
                  end
                  for (i = 0; i < shadow_count; i++) begin
                     turned[i] = shadow_words[(i + shadow_count - rot) % shadow_count];
                  end
                  for (i = 0; i < shadow_count; i++) begin
                     shadow_words[i] = turned[i];
                  end
               end
            end
         end
         MODE_READ: begin
            if (w.position >= shadow_count) begin
               r.status = STATUS_RANGE;
            end else begin
               r.read_value = shadow_words[w.position];
            end
         end
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      r.fill_count = CNT_W'(shadow_count);
      return r;
   endfunction

   // Queues one request word and tracks the fill count it will leave behind.
   function automatic void queue_word(logic [2:0] mode, int pos, logic [WORD_W-1:0] val,
                                      logic [AMT_W-1:0] amt, bit drain);
      pending_word_type p;
      p.word.mode       = mode;
      p.word.position   = CNT_W'(pos);
      p.word.item_value = val;
      p.word.amount     = amt;
      p.drain           = drain;
      send_q.push_back(p);
      case (mode)
         MODE_INSERT: begin
            if (pos <= gen_fill && gen_fill < DEPTH) gen_fill++;
         end
         MODE_REMOVE: begin
            if (pos < gen_fill) gen_fill--;
         end
         MODE_CLEAR: begin
            gen_fill = 0;
         end
         default: begin
         end
      endcase
      if (mode <= MODE_CLEAR) real_words++;
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] v;
      v = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
         endcase
      end
      return v;
   endfunction

   // Rotation distances: wide, short, whole turns and near the top of the field.
   function automatic logic [AMT_W-1:0] pick_amount(int fill);
      logic [AMT_W-1:0] a;
      case ($urandom_range(0, 3))
         0: a = AMT_W'($urandom_range(0, 65535));
         1: a = AMT_W'($urandom_range(0, 8));
         2: a = AMT_W'(fill * $urandom_range(0, 3));
         default: a = AMT_W'(65535 - $urandom_range(0, 3));
      endcase
      return a;
   endfunction

   // Request driver: presents queued words at the falling edge.
   always @(negedge clock) begin
      pending_word_type nxt;
      logic v_n;
      logic s_n;
      bit idle_ok;
      v_n = req_valid;
      s_n = 1'b0;
      idle_ok = (send_q.size() >= QUIET_TAIL) && !cycle_cnt[11];
      if (reset) begin
         v_n = 1'b0;
      end else begin
         if (req_valid && req_taken) v_n = 1'b0;
         if (!v_n) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (send_q.size() != 0 &&
                         !(send_q[0].drain && expected_rsp_q.size() != 0)) begin
               nxt = send_q.pop_front();
               req_data <= nxt.word;
               v_n = 1'b1;
               if (idle_ok && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
            end
         end
         // Response back-pressure comes in short bursts.
         if (stall_left > 0) begin
            stall_left--;
            s_n = 1'b1;
         end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            s_n = 1'b1;
         end
      end
      req_valid <= v_n;
      rsp_stall <= s_n;
   end

   // Monitor: checks responses, then predicts for each accepted request.
   always @(posedge clock) begin
      rsp_type want;
      cycle_cnt++;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response word with no request outstanding");
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_data.status, want.status));
               end
               if (rsp_data.read_value !== want.read_value) begin
                  report_mismatch($sformatf("read_value got %0d expected %0d",
                                            rsp_data.read_value, want.read_value));
               end
               if (rsp_data.fill_count !== want.fill_count) begin
                  report_mismatch($sformatf("fill_count got %0d expected %0d",
                                            rsp_data.fill_count, want.fill_count));
               end
               status_hits[want.status]++;
            end
         end
         if (req_valid && !req_stall) begin
            mode_hits[req_data.mode]++;
            expected_rsp_q.push_back(apply_request(req_data));
            if (shadow_count > peak_fill) peak_fill = shadow_count;
         end
      end
   end

   // Watchdog.
   initial begin
      wait (cycle_cnt >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_cnt, expected_rsp_q.size());
      $display("TB_ERROR");
      $finish;
   end

   // Stimulus, reset and end of run.
   initial begin
      int pick;
      int pos;
      int steps;
      int phase;
      bit drain;
      logic [2:0] mode;

      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      req_taken  = 1'b0;
      shadow_count = 0;
      gen_fill   = 0;
      real_words = 0;
      err_count  = 0;
      cycle_cnt  = 0;
      rsp_seen   = 0;
      send_gap   = 0;
      stall_left = 0;
      peak_fill  = 0;
      foreach (mode_hits[k]) mode_hits[k] = 0;
      foreach (status_hits[k]) status_hits[k] = 0;

      // Directed words: empty-array cases, field extremes, whole turns, bad indexes.
      queue_word(MODE_READ,    0,   32'h0,         16'h0,    1'b0);
      queue_word(MODE_REMOVE,  0,   32'h0,         16'h0,    1'b0);
      queue_word(MODE_ROT_R,   0,   32'h0,         16'd5,    1'b0);
      queue_word(MODE_ROT_L,   0,   32'h0,         16'hFFFF, 1'b0);
      queue_word(MODE_INSERT,  1,   32'h1234_5678, 16'h0,    1'b0);
      queue_word(MODE_INSERT,  0,   32'h7FFF_FFFF, 16'h0,    1'b0);
      queue_word(MODE_INSERT,  0,   32'h8000_0000, 16'h0,    1'b0);
      queue_word(MODE_INSERT,  2,   32'hFFFF_FFFF, 16'h0,    1'b0);
      queue_word(MODE_INSERT,  1,   32'h0,         16'h0,    1'b0);
      queue_word(MODE_ROT_R,   0,   32'h0,         16'd4,    1'b0);
      queue_word(MODE_ROT_R,   0,   32'h0,         16'd1,    1'b0);
      queue_word(MODE_ROT_L,   0,   32'h0,         16'hFFFF, 1'b0);
      queue_word(MODE_ROT_R,   0,   32'h0,         16'd0,    1'b0);
      for (pos = 0; pos < 4; pos++) begin
         queue_word(MODE_READ, pos, 32'h0, 16'h0, 1'b0);
      end
      queue_word(MODE_READ,    511, 32'h0,         16'h0,    1'b0);
      queue_word(MODE_REMOVE,  3,   32'h0,         16'h0,    1'b0);
      queue_word(MODE_REMOVE,  0,   32'h0,         16'h0,    1'b0);
      queue_word(MODE_SPARE_A, 511, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      queue_word(MODE_SPARE_B, 0,   32'h0,         16'h0,    1'b0);
      queue_word(MODE_INSERT,  511, 32'h5A5A_5A5A, 16'h0,    1'b0);
      queue_word(MODE_CLEAR,   0,   32'h0,         16'h0,    1'b0);
      queue_word(MODE_READ,    0,   32'h0,         16'h0,    1'b0);

      // Random phases; one of them fills the array to the top.
      real_words = 0;
      phase = 0;
      while (real_words < RANDOM_WORDS) begin
         drain = (phase == 0) || ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            while (gen_fill < DEPTH) begin
               queue_word(MODE_INSERT, $urandom_range(0, gen_fill), pick_word(),
                          pick_amount(gen_fill), drain);
               drain = 1'b0;
            end
            queue_word(MODE_INSERT, $urandom_range(0, DEPTH), pick_word(), 16'h0, 1'b0);
            queue_word(MODE_INSERT, DEPTH, pick_word(), 16'h0, 1'b0);
            queue_word(MODE_INSERT, $urandom_range(DEPTH + 1, 511), pick_word(), 16'h0, 1'b0);
            queue_word(MODE_READ, DEPTH - 1, pick_word(), 16'h0, 1'b0);
            queue_word(MODE_ROT_L, 0, pick_word(), pick_amount(DEPTH), 1'b0);
            queue_word(MODE_ROT_R, 0, pick_word(), pick_amount(DEPTH), 1'b0);
            queue_word(MODE_READ, $urandom_range(0, DEPTH - 1), pick_word(), 16'h0, 1'b0);
            queue_word(MODE_READ, DEPTH, pick_word(), 16'h0, 1'b0);
            queue_word(MODE_REMOVE, DEPTH, pick_word(), 16'h0, 1'b0);
            queue_word(MODE_REMOVE, $urandom_range(0, DEPTH - 1), pick_word(), 16'h0, 1'b0);
            queue_word(MODE_INSERT, 0, pick_word(), 16'h0, 1'b0);
            queue_word(MODE_INSERT, DEPTH, pick_word(), 16'h0, 1'b0);
            queue_word(MODE_CLEAR, 0, pick_word(), pick_amount(DEPTH), 1'b0);
         end else begin
            steps = $urandom_range(20, 60);
            repeat (steps) begin
               pick = $urandom_range(0, 99);
               // Keep the array small most of the time so requests stay short.
               if (pick < 35 && gen_fill > 48 && $urandom_range(0, 1) == 1) pick = 40;
               if ($urandom_range(0, 9) == 0) begin
                  pos = $urandom_range(0, 511);
               end else if (pick < 35) begin
                  pos = $urandom_range(0, gen_fill);
               end else begin
                  pos = (gen_fill > 0) ? $urandom_range(0, gen_fill - 1) : 0;
               end
               if (pick < 35) mode = MODE_INSERT;
               else if (pick < 55) mode = MODE_REMOVE;
               else if (pick < 65) mode = MODE_ROT_R;
               else if (pick < 75) mode = MODE_ROT_L;
               else if (pick < 93) mode = MODE_READ;
               else if (pick < 96) mode = MODE_CLEAR;
               else if (pick < 98) mode = MODE_SPARE_A;
               else mode = MODE_SPARE_B;
               queue_word(mode, pos, pick_word(), pick_amount(gen_fill), drain);
               drain = 1'b0;
            end
         end
         phase++;
      end

      // Hold reset, then release it at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (send_q.size() != 0 || req_valid || expected_rsp_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d responses; inserts %0d, removes %0d, rotates %0d,",
               rsp_seen, mode_hits[MODE_INSERT], mode_hits[MODE_REMOVE],
               mode_hits[MODE_ROT_R] + mode_hits[MODE_ROT_L]);
      $display("reads %0d, clears %0d, spare modes %0d; peak fill %0d; range rejects %0d, %s",
               mode_hits[MODE_READ], mode_hits[MODE_CLEAR],
               mode_hits[MODE_SPARE_A] + mode_hits[MODE_SPARE_B], peak_fill,
               status_hits[STATUS_RANGE],
               $sformatf("full rejects %0d; mismatches %0d.",
                         status_hits[STATUS_FULL], err_count));
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/asir_pkg.sv
hdl/asir_ram.sv
hdl/asir_mod.sv
hdl/array_shift_insert_remove_rotate.sv
verif/tb_array_shift_insert_remove_rotate.sv
